>>> hdl/rci_pkg.sv
package rci_pkg;

    localparam int IN_W  = 256;
    localparam int OUT_W = 168;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    localparam logic [30:0] HALF_SIDE_RST = 31'd65536;
    localparam logic [16:0] UV_MID        = 17'd32768;
    localparam logic [15:0] UV_Q_FULL     = 16'h8000;
    localparam int          UV_SHIFT      = 15;

    typedef logic signed [31:0] t_fix;

endpackage

>>> hdl/rci_div.sv
module rci_div #(
    parameter int QW = 48,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   x;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (k == 0) begin : g_first
            assign rem_in = i_rem;
            assign den_in = i_den;
            assign q_in   = i_num;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
        end

        assign x     = {rem_in, q_in[QW-1]};
        assign diff  = x - {1'b0, den_in};
        assign ge    = !diff[DW];
        assign n_rem = ge ? diff[DW-1:0] : x[DW-1:0];
        assign n_q   = {q_in[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

>>> hdl/ray_cube_intersect_uv.sv
// Ray against an origin-centered cube of configurable half side, all six faces
// tested in parallel lanes. One ray is accepted every clock unless the result
// side stalls. The depth is set by the per-face restoring dividers for the plane
// distance (one quotient bit per stage) and the texture dividers (15 stages). Back
// pressure on the result side freezes the whole pipeline; nothing is dropped or
// repeated. The user writes half_side through the cfg channel only while no ray
// is in flight; the block itself does not enforce this.
module ray_cube_intersect_uv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
    input  logic [rci_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // t_hit, face, point_x, point_y, point_z, tex_u, tex_v, zero pad
    output logic [rci_pkg::OUT_W-1:0] m_axis_tdata,
    // hit
    output logic [0:0]                m_axis_tuser,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [30:0]               i_cfg_data
);

    import rci_pkg::*;

    localparam int QW_T = 32 + FRAC_BITS;
    localparam int PW   = 65 - FRAC_BITS;
    localparam int UVQ  = UV_SHIFT;
    localparam logic signed [PW-1:0] P_MAX = PW'(64'sh0000_0000_7fff_ffff);
    localparam logic signed [PW-1:0] P_MIN = PW'(64'shffff_ffff_8000_0000);

    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
        logic [31:0]      tmin;
        logic [31:0]      tmax;
        logic [5:0]       neg;
        logic [5:0]       dz;
    } t_side;

    typedef struct packed {
        logic             ok;
        logic [2:0]       face;
        logic [31:0]      t;
        logic [2:0][PW-1:0] p;
    } t_cand;

    typedef struct packed {
        logic             hit;
        logic [2:0]       face;
        logic [31:0]      t;
        logic [2:0][PW-1:0] p;
        logic             hz;
        logic             eq_u;
        logic             eq_v;
        logic             sub_u;
        logic             sub_v;
    } t_uvs;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (a.ok && (!b.ok || $signed(a.t) <= $signed(b.t))) return a;
        return b;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = v;
        if (v > P_MAX) c = P_MAX;
        if (v < P_MIN) c = P_MIN;
        return c[31:0];
    endfunction

    logic en;
    logic [30:0] r_half;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_vo;
    logic [QW_T-1:0] r_sv;
    logic [UVQ-1:0]  r_sv2;

    assign en            = !r_vo || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_SIDE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_sv  <= '0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_sv2 <= '0;
            r_vo  <= 1'b0;
        end else if (en) begin
            r_v0  <= s_axis_tvalid;
            r_v1  <= r_v0;
            r_sv  <= {r_sv[QW_T-2:0], r_v1};
            r_v2  <= r_sv[QW_T-1];
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_sv2 <= {r_sv2[UVQ-2:0], r_v9};
            r_vo  <= r_sv2[UVQ-1];
        end
    end

    // register the ray
    logic [IN_W-1:0] r0_data;

    always_ff @(posedge i_clk) begin
        if (en) r0_data <= s_axis_tdata;
    end

    // plane distance and divider operands
    t_side       n1_side, r1_side;
    logic [31:0] n1_num [6];
    logic [31:0] n1_den [6];
    logic [31:0] r1_num [6];
    logic [31:0] r1_den [6];

    always_comb begin
        logic signed [33:0] plane;
        logic signed [33:0] diff;
        logic [31:0]        da;
        n1_side.o    = r0_data[95:0];
        n1_side.d    = r0_data[191:96];
        n1_side.tmin = r0_data[223:192];
        n1_side.tmax = r0_data[255:224];
        for (int f = 0; f < 6; f++) begin
            plane = $signed({3'b000, r_half});
            if (f % 2 == 1) plane = -plane;
            diff  = plane - 34'($signed(n1_side.o[f/2]));
            da    = n1_side.d[f/2];
            n1_num[f]      = diff[33] ? 32'(-diff) : diff[31:0];
            n1_den[f]      = da[31] ? (~da + 32'd1) : da;
            n1_side.neg[f] = diff[33] ^ da[31];
            n1_side.dz[f]  = (da == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= n1_side;
            r1_num  <= n1_num;
            r1_den  <= n1_den;
        end
    end

    logic [QW_T-1:0] w_tq [6];

    for (genvar f = 0; f < 6; f++) begin : g_tdiv
        rci_div #(
            .QW (QW_T),
            .DW (32)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (32'd0),
            .i_num ({r1_num[f], {FRAC_BITS{1'b0}}}),
            .i_den (r1_den[f]),
            .o_quo (w_tq[f])
        );
    end

    t_side r_side [QW_T];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r1_side;
            for (int k = 1; k < QW_T; k++) r_side[k] <= r_side[k-1];
        end
    end

    // sign the quotient and test the window
    logic [31:0]      n2_t [6];
    logic [5:0]       n2_ok;
    logic [31:0]      r2_t [6];
    logic [5:0]       r2_ok;
    logic [2:0][31:0] r2_o, r2_d;

    always_comb begin
        logic signed [QW_T:0] tf;
        for (int f = 0; f < 6; f++) begin
            tf = $signed({1'b0, w_tq[f]});
            if (r_side[QW_T-1].neg[f]) tf = -tf;
            n2_t[f]  = tf[31:0];
            n2_ok[f] = !r_side[QW_T-1].dz[f]
                && tf >= $signed(r_side[QW_T-1].tmin)
                && tf <= $signed(r_side[QW_T-1].tmax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t  <= n2_t;
            r2_ok <= n2_ok;
            r2_o  <= r_side[QW_T-1].o;
            r2_d  <= r_side[QW_T-1].d;
        end
    end

    // direction times t
    logic signed [63:0] r3_prod [6][3];
    logic [31:0]        r3_t [6];
    logic [5:0]         r3_ok;
    logic [2:0][31:0]   r3_o;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int f = 0; f < 6; f++) begin
                for (int i = 0; i < 3; i++) begin
                    r3_prod[f][i] <= $signed(r2_d[i]) * $signed(r2_t[f]);
                end
            end
            r3_t  <= r2_t;
            r3_ok <= r2_ok;
            r3_o  <= r2_o;
        end
    end

    // hit point
    logic [2:0][PW-1:0] n4_p [6];
    logic [2:0][PW-1:0] r4_p [6];
    logic [31:0]        r4_t [6];
    logic [5:0]         r4_ok;

    always_comb begin
        logic signed [63:0]   sh;
        logic signed [PW-1:0] shp;
        for (int f = 0; f < 6; f++) begin
            for (int i = 0; i < 3; i++) begin
                sh  = r3_prod[f][i] >>> FRAC_BITS;
                shp = sh[PW-1:0];
                n4_p[f][i] = shp + PW'($signed(r3_o[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p  <= n4_p;
            r4_t  <= r3_t;
            r4_ok <= r3_ok;
        end
    end

    // face square test
    t_cand n5_c [6];
    t_cand r5_c [6];

    always_comb begin
        logic signed [PW-1:0] hp;
        logic signed [PW-1:0] pb;
        logic signed [PW-1:0] pc;
        hp = $signed({{(PW-31){1'b0}}, r_half});
        for (int f = 0; f < 6; f++) begin
            pb = r4_p[f][(f/2 + 1) % 3];
            pc = r4_p[f][(f/2 + 2) % 3];
            n5_c[f].ok   = r4_ok[f] && pb <= hp && pb >= -hp && pc <= hp && pc >= -hp;
            n5_c[f].face = 3'(f);
            n5_c[f].t    = r4_t[f];
            n5_c[f].p    = r4_p[f];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r5_c <= n5_c;
    end

    // nearest face, earlier face on a tie
    t_cand r6_c [3];
    t_cand r7_a, r7_b, r8_best;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int w = 0; w < 3; w++) r6_c[w] <= pick(r5_c[2*w], r5_c[2*w+1]);
            r7_a    <= pick(r6_c[0], r6_c[1]);
            r7_b    <= r6_c[2];
            r8_best <= pick(r7_a, r7_b);
        end
    end

    // texture operands
    t_uvs        n9_s, r9_s;
    logic [30:0] n9_mu, n9_mv, r9_mu, r9_mv;

    always_comb begin
        logic [PW-1:0] cu, cv, au, av, hx;
        logic          su, sv;
        cu = r8_best.p[1];
        cv = r8_best.p[2];
        su = 1'b0;
        sv = 1'b0;
        case (r8_best.face)
            FACE_PX: begin
                cu = r8_best.p[1]; su = 1'b0; cv = r8_best.p[2]; sv = 1'b0;
            end
            FACE_NX: begin
                cu = r8_best.p[1]; su = 1'b1; cv = r8_best.p[2]; sv = 1'b1;
            end
            FACE_PY: begin
                cu = r8_best.p[0]; su = 1'b1; cv = r8_best.p[2]; sv = 1'b1;
            end
            FACE_NY: begin
                cu = r8_best.p[0]; su = 1'b0; cv = r8_best.p[2]; sv = 1'b0;
            end
            FACE_PZ: begin
                cu = r8_best.p[0]; su = 1'b0; cv = r8_best.p[1]; sv = 1'b0;
            end
            FACE_NZ: begin
                cu = r8_best.p[0]; su = 1'b1; cv = r8_best.p[1]; sv = 1'b1;
            end
            default: begin
                cu = r8_best.p[0]; su = 1'b0; cv = r8_best.p[1]; sv = 1'b0;
            end
        endcase
        au = cu[PW-1] ? (~cu + PW'(1)) : cu;
        av = cv[PW-1] ? (~cv + PW'(1)) : cv;
        hx = {{(PW-31){1'b0}}, r_half};
        n9_s.hit   = r8_best.ok;
        n9_s.face  = r8_best.face;
        n9_s.t     = r8_best.t;
        n9_s.p     = r8_best.p;
        n9_s.hz    = (r_half == '0);
        n9_s.eq_u  = (au == hx);
        n9_s.eq_v  = (av == hx);
        n9_s.sub_u = su ^ cu[PW-1];
        n9_s.sub_v = sv ^ cv[PW-1];
        n9_mu      = au[30:0];
        n9_mv      = av[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_s  <= n9_s;
            r9_mu <= n9_mu;
            r9_mv <= n9_mv;
        end
    end

    logic [UVQ-1:0] w_qu, w_qv;

    rci_div #(
        .QW (UVQ),
        .DW (31)
    ) u_udiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r9_mu),
        .i_num ({UVQ{1'b0}}),
        .i_den (r_half),
        .o_quo (w_qu)
    );

    rci_div #(
        .QW (UVQ),
        .DW (31)
    ) u_vdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r9_mv),
        .i_num ({UVQ{1'b0}}),
        .i_den (r_half),
        .o_quo (w_qv)
    );

    t_uvs r_uvs [UVQ];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_uvs[0] <= r9_s;
            for (int k = 1; k < UVQ; k++) r_uvs[k] <= r_uvs[k-1];
        end
    end

    // result assembly
    t_uvs             fs;
    logic [15:0]      qu, qv;
    logic [16:0]      tu, tv;
    logic [OUT_W-1:0] n_out;
    logic             n_hit;
    logic [OUT_W-1:0] r_out;
    logic             r_hit;

    always_comb begin
        fs = r_uvs[UVQ-1];
        qu = fs.hz ? 16'd0 : (fs.eq_u ? UV_Q_FULL : 16'(w_qu));
        qv = fs.hz ? 16'd0 : (fs.eq_v ? UV_Q_FULL : 16'(w_qv));
        tu = fs.sub_u ? (UV_MID - {1'b0, qu}) : (UV_MID + {1'b0, qu});
        tv = fs.sub_v ? (UV_MID - {1'b0, qv}) : (UV_MID + {1'b0, qv});
        n_hit = fs.hit;
        n_out = '0;
        if (fs.hit) begin
            n_out = {3'b000, tv, tu, sat32(fs.p[2]), sat32(fs.p[1]), sat32(fs.p[0]),
                     fs.face, fs.t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
            r_hit <= n_hit;
        end
    end

    assign m_axis_tvalid   = r_vo;
    assign m_axis_tdata    = r_out;
    assign m_axis_tuser[0] = r_hit;

endmodule

>>> hdl/rci_chk.sv
module rci_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss carries nonzero data");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[34:32] <= 3'd5
        && m_axis_tdata[147:131] <= 17'd65536 && m_axis_tdata[164:148] <= 17'd65536
        && m_axis_tdata[167:165] == 3'b000)
        else $error("hit fields out of range");

endmodule

bind ray_cube_intersect_uv rci_chk u_rci_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/ray_cube_intersect_uv_tb.sv
`timescale 1ns / 1ps

module ray_cube_intersect_uv_tb;
    import rci_pkg::*;

    localparam int LATENCY = 74;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [31:0] t_max;
        logic signed [31:0] t_min;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] org_z;
        logic signed [31:0] org_y;
        logic signed [31:0] org_x;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic [31:0] t_hit;
        logic [2:0]  face;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [16:0] u;
        logic [16:0] v;
    } t_isect;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic [0:0]         m_axis_tuser;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_data = '0;

    logic [30:0] half_side_q = HALF_SIDE_RST;
    t_isect      pending_isects[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    ray_cube_intersect_uv dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_q(longint x);
        longint one;
        one = longint'(1) << 16;
        if (x >= 0) return x / one;
        return -((-x + one - 1) / one);
    endfunction

    function automatic logic [31:0] sat_q(longint x);
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return x[31:0];
    endfunction

    function automatic logic [16:0] tex_coord(longint c, bit neg);
        longint q, r;
        q = 0;
        if (half_side_q != 0) q = (c * 32768) / longint'(half_side_q);
        r = 32768 + (neg ? -q : q);
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r[16:0];
    endfunction

    function automatic t_isect intersect_cube(t_ray r);
        t_isect res;
        longint o[3], d[3], p[3], bp[3], h, pl, t, bt, pb, pc;
        int best, a, b, c, ua, va;
        bit un, vn;
        o[0] = r.org_x; o[1] = r.org_y; o[2] = r.org_z;
        d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
        h = longint'(half_side_q);
        best = -1; bt = 0;
        bp[0] = 0; bp[1] = 0; bp[2] = 0;
        for (int f = 0; f < 6; f++) begin
            a = f >> 1;
            pl = (f & 1) ? -h : h;
            if (d[a] == 0) continue;
            t = ((pl - o[a]) * 65536) / d[a];
            if (t < longint'(r.t_min) || t > longint'(r.t_max)) continue;
            for (int i = 0; i < 3; i++) p[i] = o[i] + floor_q(d[i] * t);
            b = (a + 1) % 3; c = (a + 2) % 3;
            pb = p[b] < 0 ? -p[b] : p[b];
            pc = p[c] < 0 ? -p[c] : p[c];
            if (pb > h || pc > h) continue;
            if (best < 0 || t < bt) begin
                best = f; bt = t;
                for (int i = 0; i < 3; i++) bp[i] = p[i];
            end
        end
        res = '0;
        if (best < 0) return res;
        case (best[2:0])
            FACE_PX: begin ua = 1; un = 0; va = 2; vn = 0; end
            FACE_NX: begin ua = 1; un = 1; va = 2; vn = 1; end
            FACE_PY: begin ua = 0; un = 1; va = 2; vn = 1; end
            FACE_NY: begin ua = 0; un = 0; va = 2; vn = 0; end
            FACE_PZ: begin ua = 0; un = 0; va = 1; vn = 0; end
            default: begin ua = 0; un = 1; va = 1; vn = 1; end
        endcase
        res.hit = 1'b1;
        res.t_hit = sat_q(bt);
        res.face = best[2:0];
        res.px = sat_q(bp[0]);
        res.py = sat_q(bp[1]);
        res.pz = sat_q(bp[2]);
        res.u = tex_coord(bp[ua], un);
        res.v = tex_coord(bp[va], vn);
        return res;
    endfunction

    task automatic send_ray(t_ray r);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= r;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_isects.push_back(intersect_cube(r));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_isects.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic set_half_side(logic [30:0] hs);
        drain();
        i_cfg_data <= hs;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        half_side_q = hs;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] small_q(int mag);
        return $signed($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic t_ray aimed_ray();
        t_ray r;
        int span;
        span = (half_side_q > 31'd1000000) ? 1000000 : int'(half_side_q) * 3 + 4;
        r.org_x = small_q(span); r.org_y = small_q(span); r.org_z = small_q(span);
        r.dir_x = $urandom_range(0, 7) == 0 ? 0 : small_q(200000);
        r.dir_y = $urandom_range(0, 7) == 0 ? 0 : small_q(200000);
        r.dir_z = $urandom_range(0, 7) == 0 ? 0 : small_q(200000);
        r.t_min = $urandom_range(0, 3) == 0 ? small_q(1 << 20) : 32'h8000_0000;
        r.t_max = $urandom_range(0, 3) == 0 ? small_q(1 << 22) : 32'h7FFF_FFFF;
        return r;
    endfunction

    function automatic t_ray noise_ray();
        t_ray r;
        r = {rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word(), rand_word(), rand_word(), rand_word()};
        return r;
    endfunction

    function automatic t_ray mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int tmin, int tmax);
        t_ray r;
        r.org_x = ox; r.org_y = oy; r.org_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.t_min = tmin; r.t_max = tmax;
        return r;
    endfunction

    task automatic test_directed();
        int lo, hi;
        lo = 32'h8000_0000; hi = 32'h7FFF_FFFF;
        send_ray(mk_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, lo, hi));
        send_ray(mk_ray(3 << 16, 0, 0, -1 << 16, 0, 0, lo, hi));
        send_ray(mk_ray(0, -3 << 16, 0, 0, 1 << 16, 0, lo, hi));
        send_ray(mk_ray(0, 3 << 16, 0, 0, -1 << 16, 0, lo, hi));
        send_ray(mk_ray(0, 0, -3 << 16, 0, 0, 1 << 16, lo, hi));
        send_ray(mk_ray(0, 0, 3 << 16, 0, 0, -1 << 16, lo, hi));
        send_ray(mk_ray(-3 << 16, 0, 0, 0, 0, 0, lo, hi));
        send_ray(mk_ray(-3 << 16, 5 << 16, 0, 1 << 16, 0, 0, lo, hi));
        send_ray(mk_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 5 << 16, 1 << 16));
        send_ray(mk_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 2 << 16, 2 << 16));
        send_ray(mk_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 0, 1 << 16));
        send_ray(mk_ray(-2 << 16, -2 << 16, 0, 1 << 16, 1 << 16, 0, lo, hi));
        send_ray(mk_ray(0, 0, 0, 1 << 16, 1 << 15, 1 << 14, lo, hi));
        send_ray(mk_ray(0, 0, 0, 1 << 16, 1 << 15, 1 << 14, 0, hi));
        send_ray(mk_ray(lo, lo, lo, hi, hi, hi, lo, hi));
        send_ray(mk_ray(hi, hi, hi, lo, lo, lo, lo, hi));
        send_ray(mk_ray(lo, 0, 0, 1, 0, 0, lo, hi));
        send_ray(mk_ray(0, 0, 0, -1, -1, -1, lo, hi));
        send_ray(mk_ray(-1, -1, -1, hi, lo, 1, lo, hi));
        send_ray(mk_ray(1 << 16, 1 << 16, -3 << 16, 0, 0, 1 << 16, lo, hi));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_ray($urandom_range(0, 4) == 0 ? noise_ray() : aimed_ray());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (LATENCY * 3) @(negedge i_clk);
                hold_off = 1'b0;
            end
            test_random(LATENCY * 2);
        join
    endtask

    task automatic test_half_sides();
        set_half_side(31'd1);
        test_random(120);
        set_half_side(31'h7FFF_FFFF);
        test_random(120);
        set_half_side(31'd3 << 14);
        test_random(150);
        set_half_side(31'($urandom_range(1, 32'h7FFF_FFFF)));
        test_random(150);
        set_half_side(HALF_SIDE_RST);
        test_random(150);
    endtask

    always @(posedge i_clk) begin
        t_isect got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit = m_axis_tuser[0];
            {got.v, got.u, got.pz, got.py, got.px, got.face, got.t_hit} = m_axis_tdata[166:0];
            if (pending_isects.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = pending_isects.pop_front();
                if (got.hit !== exp_r.hit)
                    $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got.hit);
                if (got.t_hit !== exp_r.t_hit)
                    $display("%0t: t_hit exp %h got %h", $time, exp_r.t_hit, got.t_hit);
                if (got.face !== exp_r.face)
                    $display("%0t: face exp %0d got %0d", $time, exp_r.face, got.face);
                if (got.px !== exp_r.px)
                    $display("%0t: point_x exp %h got %h", $time, exp_r.px, got.px);
                if (got.py !== exp_r.py)
                    $display("%0t: point_y exp %h got %h", $time, exp_r.py, got.py);
                if (got.pz !== exp_r.pz)
                    $display("%0t: point_z exp %h got %h", $time, exp_r.pz, got.pz);
                if (got.u !== exp_r.u)
                    $display("%0t: tex_u exp %h got %h", $time, exp_r.u, got.u);
                if (got.v !== exp_r.v)
                    $display("%0t: tex_v exp %h got %h", $time, exp_r.v, got.v);
                if (got !== exp_r) errors++;
            end
        end
    end

    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && !m_axis_tvalid) begin
                m_axis_tready <= 1'b1;
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (wait_n == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_n) @(negedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ray_cube_intersect_uv");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(390);
        test_backpressure();
        test_half_sides();
        drain();
        if (errors == 0)
            $display("PASS ray_cube_intersect_uv");
        else
            $display("FAIL ray_cube_intersect_uv");
        $finish;
    end

endmodule
